FILE: src/quaternion_to_roll_angle_assert.svh
// Assertion macros for the quaternion to roll angle block.
// Included by the top-level RTL file, which checks its own logic; no other dependencies.
`ifndef QUATERNION_TO_ROLL_ANGLE_ASSERT_SVH
`define QUATERNION_TO_ROLL_ANGLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QRA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("assertion failed");
`define QRA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("assertion failed");
`else
`define QRA_ASSERT_IMP(lbl, ante, cons)
`define QRA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: src/qra_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the roll angle block.
// No dependencies.
package qra_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;
  localparam int QW               = 16;
  localparam int PW               = 32;
  localparam int DW               = 37;
  localparam int ZW               = 35;
  localparam int OUT_SHIFT        = 17;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(64'sd1686629713);
  localparam logic signed [ZW-1:0] FOLD_Q30    = ZW'(64'sd3371549327);
  localparam logic signed [ZW-1:0] ROUND_BIAS  = ZW'(64'sd65536);
  localparam logic signed [QW-1:0] ANGLE_LIMIT = QW'(25736);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_EVENT = 2'd1,
    ST_OTHER    = 2'd2
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    logic    zero;
    logic    xnp;
  } ctl_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h3243F6A8;
      1:       v = 32'h1DAC6705;
      2:       v = 32'h0FADBAFC;
      3:       v = 32'h07F56EA6;
      4:       v = 32'h03FEAB76;
      5:       v = 32'h01FFD55B;
      6:       v = 32'h00FFFAAA;
      7:       v = 32'h007FFF55;
      8:       v = 32'h003FFFEA;
      9:       v = 32'h001FFFFD;
      10:      v = 32'h000FFFFF;
      11:      v = 32'h0007FFFF;
      12:      v = 32'h0003FFFF;
      13:      v = 32'h0001FFFF;
      14:      v = 32'h0000FFFF;
      15:      v = 32'h00007FFF;
      16:      v = 32'h00003FFF;
      17:      v = 32'h00001FFF;
      18:      v = 32'h00000FFF;
      19:      v = 32'h000007FF;
      20:      v = 32'h000003FF;
      21:      v = 32'h000001FF;
      22:      v = 32'h000000FF;
      23:      v = 32'h0000007F;
      default: v = 32'h00000000;
    endcase
    atan_q30 = signed'(ZW'(v));
  endfunction

endpackage

FILE: src/qra_front.sv
// Front end: status decode, quaternion products, x/y sums and quadrant pre-rotation.
// Depends on qra_pkg. Three register stages.
module qra_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic                               event_ready,
  input  logic                               is_rotation_report,
  input  logic signed [qra_pkg::QW-1:0]      quat_i,
  input  logic signed [qra_pkg::QW-1:0]      quat_j,
  input  logic signed [qra_pkg::QW-1:0]      quat_k,
  input  logic signed [qra_pkg::QW-1:0]      quat_real,
  output qra_pkg::ctl_t                      ctl_out,
  output logic signed [qra_pkg::DW-1:0]      x_out,
  output logic signed [qra_pkg::DW-1:0]      y_out,
  output logic signed [qra_pkg::ZW-1:0]      z_out
);

  localparam int DW = qra_pkg::DW;
  localparam int ZW = qra_pkg::ZW;
  localparam int PW = qra_pkg::PW;

  // stage A: products
  qra_pkg::ctl_t         a_ctl_r, a_ctl_nxt;
  logic signed [PW-1:0]  p_ii_r, p_jj_r, p_kk_r, p_rr_r, p_jk_r, p_ir_r;
  // stage B: x and y
  qra_pkg::ctl_t         b_ctl_r, b_ctl_nxt;
  logic signed [DW-1:0]  bx_r, by_r, bx_nxt, by_nxt;
  // stage C: pre-rotation
  qra_pkg::ctl_t         c_ctl_r;
  logic signed [DW-1:0]  cx_r, cy_r, cx_nxt, cy_nxt;
  logic signed [ZW-1:0]  cz_r, cz_nxt;

  always_comb begin
    a_ctl_nxt       = '0;
    a_ctl_nxt.valid = accept;
    if (!event_ready) begin
      a_ctl_nxt.status = qra_pkg::ST_NO_EVENT;
    end else if (!is_rotation_report) begin
      a_ctl_nxt.status = qra_pkg::ST_OTHER;
    end else begin
      a_ctl_nxt.status = qra_pkg::ST_OK;
    end
  end

  always_comb begin
    by_nxt = (DW'(p_jk_r) + DW'(p_ir_r)) <<< 1;
    bx_nxt = DW'(p_kk_r) + DW'(p_rr_r) - DW'(p_ii_r) - DW'(p_jj_r);
    b_ctl_nxt      = a_ctl_r;
    b_ctl_nxt.zero = (bx_nxt == '0) && (by_nxt == '0);
    b_ctl_nxt.xnp  = bx_nxt[DW-1] || (bx_nxt == '0);
  end

  always_comb begin
    cx_nxt = bx_r;
    cy_nxt = by_r;
    cz_nxt = '0;
    if (bx_r[DW-1]) begin
      if (!by_r[DW-1]) begin
        cx_nxt = by_r;
        cy_nxt = -bx_r;
        cz_nxt = qra_pkg::HALF_PI_Q30;
      end else begin
        cx_nxt = -by_r;
        cy_nxt = bx_r;
        cz_nxt = -qra_pkg::HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
      c_ctl_r <= '0;
    end else begin
      a_ctl_r <= a_ctl_nxt;
      b_ctl_r <= b_ctl_nxt;
      c_ctl_r <= b_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    p_ii_r <= quat_i * quat_i;
    p_jj_r <= quat_j * quat_j;
    p_kk_r <= quat_k * quat_k;
    p_rr_r <= quat_real * quat_real;
    p_jk_r <= quat_j * quat_k;
    p_ir_r <= quat_i * quat_real;
    bx_r   <= bx_nxt;
    by_r   <= by_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
  end

  assign ctl_out = c_ctl_r;
  assign x_out   = cx_r;
  assign y_out   = cy_r;
  assign z_out   = cz_r;

endmodule

FILE: src/qra_cell.sv
// One CORDIC vectoring iteration with a fixed shift, registered.
// Depends on qra_pkg for widths, control struct and the arctangent table.
module qra_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qra_pkg::ctl_t                 ctl_in,
  input  logic signed [qra_pkg::DW-1:0] x_in,
  input  logic signed [qra_pkg::DW-1:0] y_in,
  input  logic signed [qra_pkg::ZW-1:0] z_in,
  output qra_pkg::ctl_t                 ctl_out,
  output logic signed [qra_pkg::DW-1:0] x_out,
  output logic signed [qra_pkg::DW-1:0] y_out,
  output logic signed [qra_pkg::ZW-1:0] z_out
);

  localparam int DW = qra_pkg::DW;
  localparam int ZW = qra_pkg::ZW;
  localparam logic signed [ZW-1:0] ANG = qra_pkg::atan_q30(IDX);

  qra_pkg::ctl_t        ctl_r;
  logic signed [DW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;

  always_comb begin
    if (!y_in[DW-1]) begin
      x_nxt = x_in + (y_in >>> IDX);
      y_nxt = y_in - (x_in >>> IDX);
      z_nxt = z_in + ANG;
    end else begin
      x_nxt = x_in - (y_in >>> IDX);
      y_nxt = y_in + (x_in >>> IDX);
      z_nxt = z_in - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign ctl_out = ctl_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule

FILE: src/qra_back.sv
// Back end: zero-vector override, +-3.14 fold, rounding to Q13 and the result register.
// Depends on qra_pkg. Two register stages.
module qra_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qra_pkg::ctl_t                 ctl_in,
  input  logic signed [qra_pkg::ZW-1:0] z_in,
  output logic                          valid,
  output logic signed [qra_pkg::QW-1:0] roll_angle,
  output logic [1:0]                    status
);

  localparam int ZW = qra_pkg::ZW;
  localparam int QW = qra_pkg::QW;

  qra_pkg::ctl_t        f_ctl_r;
  logic signed [ZW-1:0] zf_r, zf_nxt, zr;
  logic                 valid_r;
  logic signed [QW-1:0] angle_r, angle_nxt;
  qra_pkg::status_t     status_r;

  always_comb begin
    zf_nxt = z_in;
    if (ctl_in.zero) begin
      zf_nxt = '0;
    end
    if (ctl_in.xnp) begin
      if (!ctl_in.zero && !z_in[ZW-1] && (z_in != '0)) begin
        zf_nxt = z_in - qra_pkg::FOLD_Q30;
      end else begin
        zf_nxt = zf_nxt + qra_pkg::FOLD_Q30;
      end
    end
  end

  always_comb begin
    zr        = (zf_r + qra_pkg::ROUND_BIAS) >>> qra_pkg::OUT_SHIFT;
    angle_nxt = (f_ctl_r.status == qra_pkg::ST_OK) ? zr[QW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_ctl_r <= '0;
      valid_r <= 1'b0;
    end else begin
      f_ctl_r <= ctl_in;
      valid_r <= f_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    zf_r     <= zf_nxt;
    angle_r  <= angle_nxt;
    status_r <= f_ctl_r.status;
  end

  assign valid      = valid_r;
  assign roll_angle = angle_r;
  assign status     = status_r;

endmodule

FILE: src/quaternion_to_roll_angle.sv
// Top level: roll angle atan2(2(jk+ir), k^2+r^2-i^2-j^2) from a Q14 quaternion.
// Depends on qra_pkg, qra_front, qra_cell, qra_back and the assertion header.
//
//   channel   ports                          transaction
//   input     start, busy, in_*              start high, busy low at the clock edge
//   result    out_valid, out_roll_angle,     one-cycle strobe on out_valid
//             out_status
//
// One transaction per cycle; each result passes through the CORDIC cell row, whose depth
// is CORDIC_STEPS capped at qra_pkg::TABLE_LEN, plus five fixed stages.
// busy never rises. Synchronous active-low reset clears all valid flags.
// The receiver cannot stall; results are never held back.
`include "quaternion_to_roll_angle_assert.svh"
module quaternion_to_roll_angle #(
  parameter int CORDIC_STEPS = qra_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_event_ready,
  input  logic                          in_is_rotation_report,
  input  logic signed [qra_pkg::QW-1:0] in_quat_i,
  input  logic signed [qra_pkg::QW-1:0] in_quat_j,
  input  logic signed [qra_pkg::QW-1:0] in_quat_k,
  input  logic signed [qra_pkg::QW-1:0] in_quat_real,
  output logic                          out_valid,
  output logic signed [qra_pkg::QW-1:0] out_roll_angle,
  output logic [1:0]                    out_status
);

  localparam int DW    = qra_pkg::DW;
  localparam int ZW    = qra_pkg::ZW;
  localparam int STEPS = (CORDIC_STEPS > qra_pkg::TABLE_LEN) ? qra_pkg::TABLE_LEN
                                                             : CORDIC_STEPS;
  localparam int LAT   = STEPS + 5;

  qra_pkg::ctl_t        ctl_c [STEPS+1];
  logic signed [DW-1:0] x_c   [STEPS+1];
  logic signed [DW-1:0] y_c   [STEPS+1];
  logic signed [ZW-1:0] z_c   [STEPS+1];

  assign busy = 1'b0;

  qra_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (start && !busy),
    .event_ready        (in_event_ready),
    .is_rotation_report (in_is_rotation_report),
    .quat_i             (in_quat_i),
    .quat_j             (in_quat_j),
    .quat_k             (in_quat_k),
    .quat_real          (in_quat_real),
    .ctl_out            (ctl_c[0]),
    .x_out              (x_c[0]),
    .y_out              (y_c[0]),
    .z_out              (z_c[0])
  );

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    qra_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_in  (ctl_c[g]),
      .x_in    (x_c[g]),
      .y_in    (y_c[g]),
      .z_in    (z_c[g]),
      .ctl_out (ctl_c[g+1]),
      .x_out   (x_c[g+1]),
      .y_out   (y_c[g+1]),
      .z_out   (z_c[g+1])
    );
  end

  qra_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_in     (ctl_c[STEPS]),
    .z_in       (z_c[STEPS]),
    .valid      (out_valid),
    .roll_angle (out_roll_angle),
    .status     (out_status)
  );

  `QRA_ASSERT_IMP(a_latency, start && !busy, ##LAT out_valid)
  `QRA_ASSERT_IMP(a_zero_on_error, out_valid && (out_status != qra_pkg::ST_OK), out_roll_angle == '0)
  `QRA_ASSERT_IMP(a_angle_range, out_valid && (out_status == qra_pkg::ST_OK), (out_roll_angle <= qra_pkg::ANGLE_LIMIT) && (out_roll_angle >= -qra_pkg::ANGLE_LIMIT))
  `QRA_ASSERT_NXT(a_no_event_status, start && !in_event_ready, ##(LAT-1) (out_status == qra_pkg::ST_NO_EVENT))

endmodule

FILE: tb/sv/quaternion_to_roll_angle_checker.sv
// Checker for quaternion_to_roll_angle: watches the input and result channels,
// predicts the roll angle and status of each transaction and compares in order.
// Depends on qra_pkg for the status codes.
module quaternion_to_roll_angle_checker #(
  parameter int CORDIC_STEPS = qra_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_event_ready,
  input  logic                          in_is_rotation_report,
  input  logic signed [qra_pkg::QW-1:0] in_quat_i,
  input  logic signed [qra_pkg::QW-1:0] in_quat_j,
  input  logic signed [qra_pkg::QW-1:0] in_quat_k,
  input  logic signed [qra_pkg::QW-1:0] in_quat_real,
  input  logic                          out_valid,
  input  logic signed [qra_pkg::QW-1:0] out_roll_angle,
  input  logic [1:0]                    out_status,
  output int                            mismatches,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     QW         = qra_pkg::QW;
  localparam int     ITER_LIMIT = 24;
  localparam int     ITERS      = (CORDIC_STEPS > ITER_LIMIT) ? ITER_LIMIT : CORDIC_STEPS;
  localparam longint QUARTER_TURN = 64'sd1686629713;
  localparam longint FOLD_ANGLE   = 64'sd3371549327;

  typedef struct packed {
    logic signed [QW-1:0] roll;
    qra_pkg::status_t     status;
  } roll_result_t;

  longint arctan_q30 [ITER_LIMIT] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  roll_result_t roll_expect_q [$];
  int           miss_count = 0;
  int           queued = 0;

  assign mismatches = miss_count;
  assign pending    = queued;

  // vectoring CORDIC, angle in Q30 radians
  function automatic longint vector_angle(longint y_in, longint x_in);
    longint xv, yv, zv, t, dx, dy;
    xv = x_in;
    yv = y_in;
    zv = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv;
        yv = -t;
        zv = QUARTER_TURN;
      end else begin
        xv = -yv;
        yv = t;
        zv = -QUARTER_TURN;
      end
    end
    for (int n = 0; n < ITERS; n++) begin
      dx = yv >>> n;
      dy = xv >>> n;
      if (yv >= 0) begin
        xv = xv + dx;
        yv = yv - dy;
        zv = zv + arctan_q30[n];
      end else begin
        xv = xv - dx;
        yv = yv + dy;
        zv = zv - arctan_q30[n];
      end
    end
    return zv;
  endfunction

  function automatic roll_result_t predict_roll(logic ev, logic rot,
                                                logic signed [QW-1:0] qi,
                                                logic signed [QW-1:0] qj,
                                                logic signed [QW-1:0] qk,
                                                logic signed [QW-1:0] qr);
    roll_result_t r;
    longint       li, lj, lk, lr, yv, xv, z, a;
    r.roll   = '0;
    r.status = qra_pkg::ST_OK;
    if (!ev) begin
      r.status = qra_pkg::ST_NO_EVENT;
      return r;
    end
    if (!rot) begin
      r.status = qra_pkg::ST_OTHER;
      return r;
    end
    li = longint'(qi);
    lj = longint'(qj);
    lk = longint'(qk);
    lr = longint'(qr);
    yv = 2 * (lj * lk + li * lr);
    xv = lk * lk + lr * lr - li * li - lj * lj;
    z  = vector_angle(yv, xv);
    if (xv <= 0) begin
      if (z > 0) z = z - FOLD_ANGLE;
      else       z = z + FOLD_ANGLE;
    end
    a = (z + 65536) >>> qra_pkg::OUT_SHIFT;
    r.roll = a[QW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    roll_result_t want;
    if (!rst_n) begin
      roll_expect_q.delete();
      queued <= 0;
    end else begin
      if (out_valid) begin
        if (roll_expect_q.size() == 0) begin
          miss_count++;
          $display("%0t: unexpected result roll=%0d status=%0d", $time,
                   out_roll_angle, out_status);
        end else begin
          want = roll_expect_q.pop_front();
          if (out_roll_angle !== want.roll || out_status !== want.status) begin
            miss_count++;
            $display("%0t: mismatch expected roll=%0d status=%0d, actual roll=%0d status=%0d",
                     $time, want.roll, want.status, out_roll_angle, out_status);
          end
        end
      end
      if (start && !busy)
        roll_expect_q.push_back(predict_roll(in_event_ready, in_is_rotation_report,
                                             in_quat_i, in_quat_j, in_quat_k,
                                             in_quat_real));
      queued <= roll_expect_q.size();
    end
  end

endmodule

FILE: tb/sv/quaternion_to_roll_angle_test.sv
// Top of the roll angle testbench: clock, reset, directed and random transactions.
// Depends on qra_pkg, quaternion_to_roll_angle and quaternion_to_roll_angle_checker.
module quaternion_to_roll_angle_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QW          = qra_pkg::QW;
  localparam int STEPS       = qra_pkg::CORDIC_STEPS_DEF;
  localparam int LATENCY     = STEPS + 5;
  localparam int PHASE_ITEMS = 483;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic            event_ready;
    logic            is_rotation_report;
    logic signed [QW-1:0] quat_i;
    logic signed [QW-1:0] quat_j;
    logic signed [QW-1:0] quat_k;
    logic signed [QW-1:0] quat_real;
  } quat_event_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_event_ready;
  logic                 in_is_rotation_report;
  logic signed [QW-1:0] in_quat_i;
  logic signed [QW-1:0] in_quat_j;
  logic signed [QW-1:0] in_quat_k;
  logic signed [QW-1:0] in_quat_real;
  logic                 out_valid;
  logic signed [QW-1:0] out_roll_angle;
  logic [1:0]           out_status;
  int                   mismatches;
  int                   pending;
  int                   cycles = 0;

  quaternion_to_roll_angle #(.CORDIC_STEPS(STEPS)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_event_ready       (in_event_ready),
    .in_is_rotation_report(in_is_rotation_report),
    .in_quat_i            (in_quat_i),
    .in_quat_j            (in_quat_j),
    .in_quat_k            (in_quat_k),
    .in_quat_real         (in_quat_real),
    .out_valid            (out_valid),
    .out_roll_angle       (out_roll_angle),
    .out_status           (out_status)
  );

  quaternion_to_roll_angle_checker #(.CORDIC_STEPS(STEPS)) u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_event_ready       (in_event_ready),
    .in_is_rotation_report(in_is_rotation_report),
    .in_quat_i            (in_quat_i),
    .in_quat_j            (in_quat_j),
    .in_quat_k            (in_quat_k),
    .in_quat_real         (in_quat_real),
    .out_valid            (out_valid),
    .out_roll_angle       (out_roll_angle),
    .out_status           (out_status),
    .mismatches           (mismatches),
    .pending              (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic quat_event_t mk(logic ev, logic rot, int qi, int qj, int qk, int qr);
    quat_event_t e;
    e.event_ready        = ev;
    e.is_rotation_report = rot;
    e.quat_i             = QW'(qi);
    e.quat_j             = QW'(qj);
    e.quat_k             = QW'(qk);
    e.quat_real          = QW'(qr);
    return e;
  endfunction

  function automatic logic signed [QW-1:0] rand_component(int mode);
    logic signed [QW-1:0] v;
    int                   pick;
    v = QW'($urandom);
    case (mode)
      1: v = QW'(int'($urandom_range(32768)) - 16384);
      2: if ($urandom_range(1) == 0) v = '0;
      3: begin
        pick = $urandom_range(6);
        case (pick)
          0: v = -16'sd32768;
          1: v = -16'sd1;
          2: v = 16'sd0;
          3: v = 16'sd1;
          4: v = 16'sd32767;
          5: v = 16'sd16384;
          default: v = -16'sd16384;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic quat_event_t rand_event();
    quat_event_t e;
    int          kind;
    int          mode;
    kind = $urandom_range(99);
    mode = $urandom_range(3);
    e.event_ready        = 1'b1;
    e.is_rotation_report = 1'b1;
    e.quat_i             = rand_component(mode);
    e.quat_j             = rand_component(mode);
    e.quat_k             = rand_component(mode);
    e.quat_real          = rand_component(mode);
    if (kind < 5) begin
      e.event_ready        = 1'b0;
      e.is_rotation_report = 1'($urandom_range(1));
    end else if (kind < 10) begin
      e.is_rotation_report = 1'b0;
    end
    return e;
  endfunction

  // entered and left just after a falling edge
  task automatic send_event(quat_event_t e);
    logic stalled;
    in_event_ready        <= e.event_ready;
    in_is_rotation_report <= e.is_rotation_report;
    in_quat_i             <= e.quat_i;
    in_quat_j             <= e.quat_j;
    in_quat_k             <= e.quat_k;
    in_quat_real          <= e.quat_real;
    start                 <= 1'b1;
    do begin
      stalled = busy;
      @(posedge clk);
      @(negedge clk);
    end while (stalled);
  endtask

  task automatic idle_gap(int pct);
    while (int'($urandom_range(99)) < pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic run_phase(int pct);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      idle_gap(pct);
      send_event(rand_event());
    end
  endtask

  initial begin
    quat_event_t directed [$];
    int          drain;
    start                 = 1'b0;
    in_event_ready        = 1'b0;
    in_is_rotation_report = 1'b0;
    in_quat_i             = '0;
    in_quat_j             = '0;
    in_quat_k             = '0;
    in_quat_real          = '0;
    rst_n                 = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // no event, other report, zero vector, negative x axis, quadrants, extremes
    directed.push_back(mk(1'b0, 1'b0, 0, 0, 0, 0));
    directed.push_back(mk(1'b0, 1'b1, -1, -1, -1, -1));
    directed.push_back(mk(1'b1, 1'b0, 32767, -32768, 32767, -32768));
    directed.push_back(mk(1'b1, 1'b1, 0, 0, 0, 0));
    directed.push_back(mk(1'b1, 1'b1, 16384, 0, 0, 0));
    directed.push_back(mk(1'b1, 1'b1, 0, 16384, 0, 0));
    directed.push_back(mk(1'b1, 1'b1, -32768, 0, 0, 0));
    directed.push_back(mk(1'b1, 1'b1, 0, 0, 0, 16384));
    directed.push_back(mk(1'b1, 1'b1, 0, 0, 16384, 0));
    directed.push_back(mk(1'b1, 1'b1, 16384, 0, 0, 8000));
    directed.push_back(mk(1'b1, 1'b1, 16384, 0, 0, -8000));
    directed.push_back(mk(1'b1, 1'b1, 8000, 0, 0, 16384));
    directed.push_back(mk(1'b1, 1'b1, -8000, 0, 0, 16384));
    directed.push_back(mk(1'b1, 1'b1, 11585, 0, 0, 11585));
    directed.push_back(mk(1'b1, 1'b1, -11585, 0, 0, 11585));
    directed.push_back(mk(1'b1, 1'b1, -32768, -32768, -32768, -32768));
    directed.push_back(mk(1'b1, 1'b1, 32767, 32767, 32767, 32767));
    directed.push_back(mk(1'b1, 1'b1, -32768, 32767, -32768, 32767));
    directed.push_back(mk(1'b1, 1'b1, 32767, -32768, -32768, 32767));
    directed.push_back(mk(1'b1, 1'b1, 0, 11585, 11585, 0));
    directed.push_back(mk(1'b1, 1'b1, 1, 0, 0, 0));
    directed.push_back(mk(1'b1, 1'b1, 0, 0, 0, -1));
    directed.push_back(mk(1'b1, 1'b1, 0, 1, 1, 0));
    directed.push_back(mk(1'b1, 1'b1, 0, -1, 1, 0));
    foreach (directed[n]) send_event(directed[n]);

    run_phase(25);
    run_phase(76);
    run_phase(0);
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    drain = 0;
    while (drain < LATENCY + 10) begin
      @(negedge clk);
      drain++;
    end

    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
